// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property shorthands for the relative time event queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RTEQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rteq assertion failed");
`define RTEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rteq implication failed");
`else
`define RTEQ_ASSERT(label, clk, rst_n, prop)
`define RTEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/rteq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rteq_pkg
// Shared types, codes and defaults of the relative time event queue.
// ----------------------------------------------------------------------------
package rteq_pkg;

	localparam int POOL_DEPTH_DEF = 32;
	localparam int DELTA_BITS_DEF = 16;
	localparam int TAG_BITS_DEF   = 16;
	localparam int MAX_RESULTS    = 32;

	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_DELETE  = 2'd1;
	localparam logic [1:0] KIND_ADVANCE = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_POOL  = 3'd1;
	localparam logic [2:0] ST_NOT_QUED = 3'd2;
	localparam logic [2:0] ST_EXPIRED  = 3'd3;
	localparam logic [2:0] ST_NOTHING  = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] event_tag;
		logic [31:0] delay;
		logic [4:0]  handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  slot;
		logic [15:0] expired_tag;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_INS_WALK,
		CMD_INS_CNT,
		CMD_FILL_A,
		CMD_FILL_B,
		CMD_EV_A,
		CMD_EV_B,
		CMD_DEL_A,
		CMD_DEL_B,
		CMD_DEL_C,
		CMD_STRIP_A,
		CMD_STRIP_B,
		CMD_ADV_POP,
		CMD_ADV_FIN,
		CMD_EMIT
	} cmd_t;

	typedef struct packed {
		logic walk_go;
		logic cnt_busy;
		logic reject;
		logic fill_nz;
		logic fill_more;
		logic del_bad;
		logic del_merge;
		logic p_valid;
		logic strip;
		logic strip_p_valid;
		logic adv_more;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: src/rteq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rteq_dp
// Entry pool, list pointers, working registers and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rteq_dp #(
	parameter int POOL_DEPTH = rteq_pkg::POOL_DEPTH_DEF,
	parameter int DELTA_BITS = rteq_pkg::DELTA_BITS_DEF,
	parameter int TAG_BITS   = rteq_pkg::TAG_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rteq_pkg::cmd_t cmd,
	input  wire rteq_pkg::req_t req,
	input  wire logic          cfg_we,
	input  wire logic [15:0]   cfg_wdata,
	input  wire logic          rsp_stall,
	output logic               rsp_valid,
	output rteq_pkg::rsp_t     rsp,
	output rteq_pkg::stat_t    stat
);
	localparam int LW = $clog2(POOL_DEPTH + 1);
	localparam int IW = $clog2(POOL_DEPTH);
	localparam int KW = $clog2(rteq_pkg::MAX_RESULTS + 1);
	localparam logic [LW-1:0] NONE = LW'(POOL_DEPTH);

	logic [DELTA_BITS-1:0] delta_mem [POOL_DEPTH];
	logic [TAG_BITS-1:0]   label_mem [POOL_DEPTH];
	logic                  filler_mem [POOL_DEPTH];
	logic [LW-1:0]         prev_mem [POOL_DEPTH];
	logic                  in_use_q [POOL_DEPTH];
	logic [LW-1:0]         next_q [POOL_DEPTH];

	logic [15:0]           max_delta_q;
	logic [LW-1:0]         head_q, tail_q, free_head_q, free_cnt_q;
	logic [LW-1:0]         cur_q, last_q, new_q, p_q, n_q, h_q;
	logic                  h_ok_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [31:0]           t_q, tt_q;
	logic [DELTA_BITS-1:0] dh_q;
	logic [LW-1:0]         fillk_q, guard_q;
	logic [KW-1:0]         k_q;
	rteq_pkg::rsp_t        pend_q, out_q;
	logic                  pend_v_q, out_v_q;

	logic [DELTA_BITS-1:0] md_raw, md;
	logic [31:0]           md32;
	logic [LW-1:0]         rd_lnk;
	logic [IW-1:0]         rd_idx;
	logic [DELTA_BITS-1:0] rd_delta;
	logic [TAG_BITS-1:0]   rd_label;
	logic                  rd_filler, rd_in_use;
	logic [LW-1:0]         rd_next, rd_prev;
	logic                  cur_ok, last_ok, head_ok, tail_ok, n_ok, p_ok;
	logic [DELTA_BITS:0]   merge_sum;
	logic                  walk_go, cnt_busy, reject, del_bad, merge, strip;
	logic                  adv_cond, adv_cap, adv_pop, adv_go, nf, out_free, out_load;

	// write strobes, one address per array per cycle
	logic                  wd_en, wl_en, wf_en, wp_en, wu_en, wn_en;
	logic [IW-1:0]         wd_a, wl_a, wf_a, wp_a, wu_a, wn_a;
	logic [DELTA_BITS-1:0] wd_d;
	logic                  wf_d, wu_d;
	logic [LW-1:0]         wp_d, wn_d;

	assign md_raw = DELTA_BITS'(max_delta_q);
	assign md     = (md_raw == '0) ? DELTA_BITS'(1) : md_raw;
	assign md32   = 32'(md);

	always_comb begin
		case (cmd)
			rteq_pkg::CMD_INS_WALK, rteq_pkg::CMD_EV_B: rd_lnk = cur_q;
			rteq_pkg::CMD_FILL_A, rteq_pkg::CMD_EV_A:   rd_lnk = free_head_q;
			rteq_pkg::CMD_DEL_A:                        rd_lnk = h_q;
			rteq_pkg::CMD_DEL_B:                        rd_lnk = n_q;
			rteq_pkg::CMD_STRIP_A:                      rd_lnk = tail_q;
			default:                                    rd_lnk = head_q;
		endcase
	end

	assign rd_idx    = rd_lnk[IW-1:0];
	assign rd_delta  = delta_mem[rd_idx];
	assign rd_label  = label_mem[rd_idx];
	assign rd_filler = filler_mem[rd_idx];
	assign rd_prev   = prev_mem[rd_idx];
	assign rd_in_use = in_use_q[rd_idx];
	assign rd_next   = next_q[rd_idx];

	assign cur_ok  = cur_q < NONE;
	assign last_ok = last_q < NONE;
	assign head_ok = head_q < NONE;
	assign tail_ok = tail_q < NONE;
	assign n_ok    = n_q < NONE;
	assign p_ok    = p_q < NONE;

	assign walk_go  = cur_ok && (guard_q < NONE) && (32'(rd_delta) < t_q);
	assign cnt_busy = !cur_ok && (tt_q > md32) && (fillk_q < free_cnt_q);
	assign reject   = (!cur_ok && (tt_q > md32)) || (fillk_q >= free_cnt_q);
	assign del_bad  = !h_ok_q || !rd_in_use || rd_filler;
	assign merge_sum = {1'b0, rd_delta} + {1'b0, dh_q};
	assign merge    = !n_ok || (dh_q == '0) || (merge_sum <= {1'b0, md});
	assign strip    = tail_ok && rd_filler;
	assign nf       = !rd_filler;
	assign adv_cond = head_ok && (32'(rd_delta) <= t_q);
	assign adv_cap  = adv_cond && nf && (k_q >= KW'(rteq_pkg::MAX_RESULTS));
	assign adv_pop  = adv_cond && !adv_cap;
	assign out_free = !out_v_q || !rsp_stall;
	// an expired event must first push the previous one out
	assign adv_go   = adv_pop && !(nf && pend_v_q && !out_free);
	assign out_load = ((cmd == rteq_pkg::CMD_EMIT) && out_free) ||
	                  ((cmd == rteq_pkg::CMD_ADV_POP) && adv_go && nf && pend_v_q);

	always_comb begin
		stat.walk_go       = walk_go;
		stat.cnt_busy      = cnt_busy;
		stat.reject        = reject;
		stat.fill_nz       = fillk_q != '0;
		stat.fill_more     = fillk_q > LW'(1);
		stat.del_bad       = del_bad;
		stat.del_merge     = merge;
		stat.p_valid       = p_ok;
		stat.strip         = strip;
		stat.strip_p_valid = rd_prev < NONE;
		stat.adv_more      = adv_pop;
		stat.out_free      = out_free;
	end

	always_comb begin
		wd_en = 1'b0; wd_a = rd_idx; wd_d = '0;
		wl_en = 1'b0; wl_a = rd_idx;
		wf_en = 1'b0; wf_a = rd_idx; wf_d = 1'b0;
		wp_en = 1'b0; wp_a = rd_idx; wp_d = NONE;
		wu_en = 1'b0; wu_a = rd_idx; wu_d = 1'b0;
		wn_en = 1'b0; wn_a = rd_idx; wn_d = NONE;
		case (cmd)
			rteq_pkg::CMD_FILL_A: begin
				wu_en = 1'b1; wu_d = 1'b1;
				wf_en = 1'b1; wf_d = 1'b1;
				wd_en = 1'b1; wd_d = md;
				wn_en = 1'b1; wn_d = NONE;
				wp_en = 1'b1; wp_d = last_q;
			end
			rteq_pkg::CMD_FILL_B: begin
				wn_en = last_ok; wn_a = last_q[IW-1:0]; wn_d = new_q;
			end
			rteq_pkg::CMD_EV_A: begin
				wu_en = 1'b1; wu_d = 1'b1;
				wf_en = 1'b1; wf_d = 1'b0;
				wl_en = 1'b1;
				wd_en = 1'b1; wd_d = t_q[DELTA_BITS-1:0];
				wn_en = 1'b1; wn_d = cur_q;
				wp_en = 1'b1; wp_d = last_q;
			end
			rteq_pkg::CMD_EV_B: begin
				wn_en = last_ok; wn_a = last_q[IW-1:0]; wn_d = new_q;
				wp_en = cur_ok; wp_d = new_q;
				wd_en = cur_ok; wd_d = rd_delta - t_q[DELTA_BITS-1:0];
			end
			rteq_pkg::CMD_DEL_B: begin
				wf_a = h_q[IW-1:0];
				wf_en = 1'b1;
				if (merge) begin
					wd_en = n_ok; wd_d = merge_sum[DELTA_BITS-1:0];
					wp_en = n_ok; wp_d = p_q;
					wu_en = 1'b1; wu_a = h_q[IW-1:0]; wu_d = 1'b0;
					wf_d = 1'b0;
					wn_en = 1'b1; wn_a = h_q[IW-1:0]; wn_d = free_head_q;
				end else begin
					wf_d = 1'b1;
				end
			end
			rteq_pkg::CMD_DEL_C: begin
				wn_en = 1'b1; wn_a = p_q[IW-1:0]; wn_d = n_q;
			end
			rteq_pkg::CMD_STRIP_A: begin
				wu_en = strip; wu_d = 1'b0;
				wf_en = strip; wf_d = 1'b0;
				wn_en = strip; wn_d = free_head_q;
			end
			rteq_pkg::CMD_STRIP_B: begin
				wn_en = 1'b1; wn_a = p_q[IW-1:0]; wn_d = NONE;
			end
			rteq_pkg::CMD_ADV_POP: begin
				wp_en = adv_go && (rd_next < NONE); wp_a = rd_next[IW-1:0]; wp_d = NONE;
				wu_en = adv_go; wu_d = 1'b0;
				wf_en = adv_go; wf_d = 1'b0;
				wn_en = adv_go; wn_d = free_head_q;
			end
			rteq_pkg::CMD_ADV_FIN: begin
				wd_en = head_ok; wd_d = rd_delta - t_q[DELTA_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wd_en) delta_mem[wd_a] <= wd_d;
		if (wl_en) label_mem[wl_a] <= tag_q;
		if (wf_en) filler_mem[wf_a] <= wf_d;
		if (wp_en) prev_mem[wp_a] <= wp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_DEPTH; i++) begin
				in_use_q[i] <= 1'b0;
				next_q[i]   <= LW'(i + 1);
			end
		end else begin
			if (wu_en) in_use_q[wu_a] <= wu_d;
			if (wn_en) next_q[wn_a] <= wn_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delta_q <= 16'hFFFF;
			head_q      <= NONE;
			tail_q      <= NONE;
			free_head_q <= '0;
			free_cnt_q  <= LW'(POOL_DEPTH);
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_we) max_delta_q <= cfg_wdata;
			out_v_q <= out_load ? 1'b1 : (out_v_q && rsp_stall);
			case (cmd)
				rteq_pkg::CMD_INS_CNT: begin
					if (!cnt_busy && reject) pend_v_q <= 1'b1;
				end
				rteq_pkg::CMD_FILL_A: begin
					free_head_q <= rd_next;
					free_cnt_q  <= free_cnt_q - LW'(1);
					tail_q      <= free_head_q;
					if (!last_ok) head_q <= free_head_q;
				end
				rteq_pkg::CMD_EV_A: begin
					free_head_q <= rd_next;
					free_cnt_q  <= free_cnt_q - LW'(1);
					if (!last_ok) head_q <= free_head_q;
					if (!cur_ok) tail_q <= free_head_q;
				end
				rteq_pkg::CMD_EV_B: pend_v_q <= 1'b1;
				rteq_pkg::CMD_DEL_A: begin
					if (del_bad) pend_v_q <= 1'b1;
				end
				rteq_pkg::CMD_DEL_B: begin
					if (merge) begin
						if (!n_ok) tail_q <= p_q;
						if (!p_ok) head_q <= n_q;
						free_head_q <= h_q;
						free_cnt_q  <= free_cnt_q + LW'(1);
					end
				end
				rteq_pkg::CMD_STRIP_A: begin
					if (strip) begin
						tail_q <= rd_prev;
						if (!(rd_prev < NONE)) head_q <= NONE;
						free_head_q <= tail_q;
						free_cnt_q  <= free_cnt_q + LW'(1);
					end else begin
						pend_v_q <= 1'b1;
					end
				end
				rteq_pkg::CMD_ADV_POP: begin
					if (adv_go) begin
						head_q <= rd_next;
						if (!(rd_next < NONE)) tail_q <= NONE;
						free_head_q <= head_q;
						free_cnt_q  <= free_cnt_q + LW'(1);
						if (nf) pend_v_q <= 1'b1;
					end
				end
				rteq_pkg::CMD_ADV_FIN: pend_v_q <= 1'b1;
				rteq_pkg::CMD_EMIT: begin
					if (out_free) pend_v_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= pend_q;
		case (cmd)
			rteq_pkg::CMD_LOAD: begin
				t_q     <= req.delay;
				tt_q    <= req.delay;
				cur_q   <= head_q;
				last_q  <= NONE;
				guard_q <= '0;
				fillk_q <= '0;
				k_q     <= '0;
				tag_q   <= TAG_BITS'(req.event_tag);
				h_ok_q  <= 32'(req.handle) < 32'(POOL_DEPTH);
				h_q     <= LW'(req.handle);
			end
			rteq_pkg::CMD_INS_WALK: begin
				if (walk_go) begin
					t_q     <= t_q - 32'(rd_delta);
					tt_q    <= t_q - 32'(rd_delta);
					last_q  <= cur_q;
					cur_q   <= rd_next;
					guard_q <= guard_q + LW'(1);
				end
			end
			rteq_pkg::CMD_INS_CNT: begin
				if (cnt_busy) begin
					tt_q    <= tt_q - md32;
					fillk_q <= fillk_q + LW'(1);
				end else if (reject) begin
					pend_q <= '{status: rteq_pkg::ST_NO_POOL, slot: 5'd0,
					            expired_tag: 16'd0, last: 1'b1};
				end
			end
			rteq_pkg::CMD_FILL_A: new_q <= free_head_q;
			rteq_pkg::CMD_FILL_B: begin
				t_q     <= t_q - md32;
				fillk_q <= fillk_q - LW'(1);
				last_q  <= new_q;
			end
			rteq_pkg::CMD_EV_A: new_q <= free_head_q;
			rteq_pkg::CMD_EV_B: begin
				pend_q <= '{status: rteq_pkg::ST_OK, slot: 5'(new_q),
				            expired_tag: 16'd0, last: 1'b1};
			end
			rteq_pkg::CMD_DEL_A: begin
				n_q  <= rd_next;
				p_q  <= rd_prev;
				dh_q <= rd_delta;
				if (del_bad) begin
					pend_q <= '{status: rteq_pkg::ST_NOT_QUED, slot: 5'd0,
					            expired_tag: 16'd0, last: 1'b1};
				end
			end
			rteq_pkg::CMD_STRIP_A: begin
				p_q <= rd_prev;
				if (!strip) begin
					pend_q <= '{status: rteq_pkg::ST_OK, slot: 5'(h_q),
					            expired_tag: 16'd0, last: 1'b1};
				end
			end
			rteq_pkg::CMD_ADV_POP: begin
				if (adv_cap) begin
					// result budget spent: head stays expired at zero delta
					t_q <= 32'(rd_delta);
				end else if (adv_go) begin
					t_q <= t_q - 32'(rd_delta);
					if (nf) begin
						k_q    <= k_q + KW'(1);
						pend_q <= '{status: rteq_pkg::ST_EXPIRED, slot: 5'(head_q),
						            expired_tag: 16'(rd_label), last: 1'b0};
					end
				end
			end
			rteq_pkg::CMD_ADV_FIN: begin
				if (pend_v_q) begin
					pend_q.last <= 1'b1;
				end else begin
					pend_q <= '{status: rteq_pkg::ST_NOTHING, slot: 5'd0,
					            expired_tag: 16'd0, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	`RTEQ_ASSERT(a_free_cnt_range, clk, arst_n, free_cnt_q <= LW'(POOL_DEPTH))
	`RTEQ_ASSERT(a_head_tail_pair, clk, arst_n, (head_q == NONE) == (tail_q == NONE))
	`RTEQ_ASSERT_IMPL(a_load_no_pend, clk, arst_n, cmd == rteq_pkg::CMD_LOAD, !pend_v_q)
	`RTEQ_ASSERT_IMPL(a_alloc_has_free, clk, arst_n,
		(cmd == rteq_pkg::CMD_EV_A) || (cmd == rteq_pkg::CMD_FILL_A), free_cnt_q != '0)

endmodule
`default_nettype wire

// File: src/rteq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rteq_ctrl
// Sequencer for insert, delete and advance transactions.
// ----------------------------------------------------------------------------
module rteq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic [1:0]      kind,
	input  wire rteq_pkg::stat_t stat,
	output logic                 req_stall,
	output rteq_pkg::cmd_t       cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_INS_WALK, S_INS_CNT, S_FILL_A, S_FILL_B, S_EV_A, S_EV_B,
		S_DEL_A, S_DEL_B, S_DEL_C, S_STRIP_A, S_STRIP_B, S_ADV_POP, S_ADV_FIN, S_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && (state_q == S_IDLE);

	always_comb begin
		case (state_q)
			S_IDLE:     cmd = accept ? rteq_pkg::CMD_LOAD : rteq_pkg::CMD_NOP;
			S_INS_WALK: cmd = rteq_pkg::CMD_INS_WALK;
			S_INS_CNT:  cmd = rteq_pkg::CMD_INS_CNT;
			S_FILL_A:   cmd = rteq_pkg::CMD_FILL_A;
			S_FILL_B:   cmd = rteq_pkg::CMD_FILL_B;
			S_EV_A:     cmd = rteq_pkg::CMD_EV_A;
			S_EV_B:     cmd = rteq_pkg::CMD_EV_B;
			S_DEL_A:    cmd = rteq_pkg::CMD_DEL_A;
			S_DEL_B:    cmd = rteq_pkg::CMD_DEL_B;
			S_DEL_C:    cmd = rteq_pkg::CMD_DEL_C;
			S_STRIP_A:  cmd = rteq_pkg::CMD_STRIP_A;
			S_STRIP_B:  cmd = rteq_pkg::CMD_STRIP_B;
			S_ADV_POP:  cmd = rteq_pkg::CMD_ADV_POP;
			S_ADV_FIN:  cmd = rteq_pkg::CMD_ADV_FIN;
			S_EMIT:     cmd = rteq_pkg::CMD_EMIT;
			default:    cmd = rteq_pkg::CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							rteq_pkg::KIND_INSERT:  state_q <= S_INS_WALK;
							rteq_pkg::KIND_DELETE:  state_q <= S_DEL_A;
							rteq_pkg::KIND_ADVANCE: state_q <= S_ADV_POP;
							default:                state_q <= S_IDLE;
						endcase
					end
				end
				S_INS_WALK: if (!stat.walk_go) state_q <= S_INS_CNT;
				S_INS_CNT: begin
					if (!stat.cnt_busy) begin
						if (stat.reject)       state_q <= S_EMIT;
						else if (stat.fill_nz) state_q <= S_FILL_A;
						else                   state_q <= S_EV_A;
					end
				end
				S_FILL_A: state_q <= S_FILL_B;
				S_FILL_B: state_q <= stat.fill_more ? S_FILL_A : S_EV_A;
				S_EV_A:   state_q <= S_EV_B;
				S_EV_B:   state_q <= S_EMIT;
				S_DEL_A:  state_q <= stat.del_bad ? S_EMIT : S_DEL_B;
				S_DEL_B:  state_q <= (stat.del_merge && stat.p_valid) ? S_DEL_C : S_STRIP_A;
				S_DEL_C:  state_q <= S_STRIP_A;
				S_STRIP_A: begin
					if (!stat.strip)             state_q <= S_EMIT;
					else if (stat.strip_p_valid) state_q <= S_STRIP_B;
				end
				S_STRIP_B: state_q <= S_STRIP_A;
				S_ADV_POP: if (!stat.adv_more) state_q <= S_ADV_FIN;
				S_ADV_FIN: state_q <= S_EMIT;
				S_EMIT:    if (stat.out_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/relative_time_event_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: insert walks the list, counts the fillers it needs, adds each filler, then the event;
//   delete stops early on a bad handle, else unlinks or marks the entry and strips trailing fillers;
//   advance pops each expired entry, then updates the delta of the new head.
// Throughput: one transaction at a time; req_stall holds off new requests until the
//   current one has emitted its response.
// Reset: asynchronous, empty queue, free chain 0..N-1, max_delta all ones; ready at once.
// ----------------------------------------------------------------------------
// relative_time_event_queue
// Delta-list timer queue over a fixed entry pool with filler padding.
// ----------------------------------------------------------------------------
module relative_time_event_queue #(
	parameter int POOL_DEPTH = rteq_pkg::POOL_DEPTH_DEF,
	parameter int DELTA_BITS = rteq_pkg::DELTA_BITS_DEF,
	parameter int TAG_BITS   = rteq_pkg::TAG_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire rteq_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output rteq_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_wdata
);
	rteq_pkg::cmd_t  cmd;
	rteq_pkg::stat_t stat;

	rteq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.kind      (req.kind),
		.stat      (stat),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	rteq_dp #(
		.POOL_DEPTH (POOL_DEPTH),
		.DELTA_BITS (DELTA_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.stat      (stat)
	);

endmodule
`default_nettype wire
